>>> sv/fsvq_pkg.sv
// Types and constants shared by the flow sensor validity qualifier.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fsvq_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_QUALITY_THRESHOLD  = 2'd0;
    localparam logic [1:0] CFG_QUALITY_QUALIFY_MS = 2'd1;
    localparam logic [1:0] CFG_HEIGHT_LIMIT_CM    = 2'd2;
    localparam logic [1:0] CFG_HEIGHT_QUALIFY_MS  = 2'd3;

    // Reset values of the configuration registers
    localparam logic [7:0]  QUALITY_THRESHOLD_RST  = 8'd50;
    localparam logic [15:0] QUALITY_QUALIFY_MS_RST = 16'd500;
    localparam logic [15:0] HEIGHT_LIMIT_CM_RST    = 16'd600;
    localparam logic [10:0] HEIGHT_QUALIFY_MS_RST  = 11'd1000;

    // Quality timer saturates here
    localparam logic [9:0] QTIMER_MAX = 10'd1023;

    // Height timer width, signed: spans -2048 to 2047, enough for qualify times up to 1793 plus one tick
    localparam int HTIMER_W = 12;

    typedef struct packed {
        logic [7:0]  tick_ms;
        logic        primary_present;
        logic        fused_present;
        logic [7:0]  primary_quality;
        logic [15:0] primary_height_cm;
        logic [7:0]  fused_quality;
        logic [15:0] fused_height_cm;
        logic        position_hold;
        logic        uwb_online;
        logic        camera_offline;
    } fsvq_item_t;

    typedef struct packed {
        logic        flow_enable;
        logic        flow_height_enable;
        logic        uwb_enable;
        logic        camera_enable;
        logic [15:0] valid_height_cm;
    } fsvq_result_t;

    typedef struct packed {
        logic [1:0]  reg_index;
        logic [15:0] wdata;
    } fsvq_cfg_wr_t;

    typedef struct packed {
        logic [7:0]  quality_threshold;
        logic [15:0] quality_qualify_ms;
        logic [15:0] height_limit_cm;
        logic [10:0] height_qualify_ms;
    } fsvq_cfg_t;

endpackage

`default_nettype wire

>>> sv/fsvq_if.sv
// Valid/ready channel interfaces for tick items, results and register writes.
// Depends on fsvq_pkg for the payload types.
`default_nettype none

interface fsvq_item_if;
    import fsvq_pkg::*;
    logic       valid;
    logic       ready;
    fsvq_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fsvq_result_if;
    import fsvq_pkg::*;
    logic         valid;
    logic         ready;
    fsvq_result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fsvq_cfg_if;
    import fsvq_pkg::*;
    logic         valid;
    logic         ready;
    fsvq_cfg_wr_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/flow_sensor_validity_qualifier_unit.sv
// Top level of the flow sensor validity qualifier: input register, core, result register.
// Depends on fsvq_pkg, fsvq_if, fsvq_cfg_regs and fsvq_core.
//
//   channel  role    payload         width
//   item     sink    fsvq_item_t     61
//   result   source  fsvq_result_t   20
//   cfg      sink    fsvq_cfg_wr_t   18
//
// One tick per cycle sustained while the result side is ready; each item passes the input
// register and then the result register before its result is offered.
// The state loop of fsvq_core closes through its state registers, between the input and result registers.
// Reset clears all qualification state and loads the register defaults.
// A stalled result holds in the result register; one more item waits in the input register.
`default_nettype none

module flow_sensor_validity_qualifier_unit
    import fsvq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    fsvq_item_if.sink      item,
    fsvq_result_if.source  result,
    fsvq_cfg_if.sink       cfg
);

    logic         in_valid_reg;
    fsvq_item_t   in_data_reg;
    logic         out_valid_reg;
    fsvq_result_t out_data_reg;
    fsvq_cfg_t    regs;
    fsvq_result_t core_res;
    logic         advance;
    logic         step;

    // Pipeline flow control
    assign advance    = ~out_valid_reg | result.ready;
    assign step       = in_valid_reg & advance;
    assign item.ready = ~in_valid_reg | advance;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    fsvq_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    fsvq_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_data_reg),
        .regs  (regs),
        .res   (core_res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item.ready)
            in_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            in_data_reg <= item.data;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= core_res;
    end

endmodule

`default_nettype wire

>>> sv/fsvq_cfg_regs.sv
// Configuration register file: four threshold and qualify-time registers.
// Depends on fsvq_pkg and fsvq_cfg_if.
`default_nettype none

module fsvq_cfg_regs
    import fsvq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    fsvq_cfg_if.sink    cfg,
    output fsvq_cfg_t   regs
);

    fsvq_cfg_t regs_reg;
    fsvq_cfg_t regs_next;

    // Writes are always taken
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Register select
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.data.reg_index)
                CFG_QUALITY_THRESHOLD:  regs_next.quality_threshold  = cfg.data.wdata[7:0];
                CFG_QUALITY_QUALIFY_MS: regs_next.quality_qualify_ms = cfg.data.wdata;
                CFG_HEIGHT_LIMIT_CM:    regs_next.height_limit_cm    = cfg.data.wdata;
                CFG_HEIGHT_QUALIFY_MS:  regs_next.height_qualify_ms  = cfg.data.wdata[10:0];
                default:                regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.quality_threshold  <= QUALITY_THRESHOLD_RST;
            regs_reg.quality_qualify_ms <= QUALITY_QUALIFY_MS_RST;
            regs_reg.height_limit_cm    <= HEIGHT_LIMIT_CM_RST;
            regs_reg.height_qualify_ms  <= HEIGHT_QUALIFY_MS_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/fsvq_core.sv
// Qualification state and per-tick decision logic.
// Depends on fsvq_pkg; state advances once for each item taken from the input register.
`default_nettype none

module fsvq_core
    import fsvq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   step,
    input  wire fsvq_item_t item,
    input  wire fsvq_cfg_t  regs,
    output fsvq_result_t res
);

    logic [9:0]                 qtimer_reg, qtimer_next;
    logic                       qgood_reg, qgood_next;
    logic signed [HTIMER_W-1:0] htimer_reg, htimer_next;
    logic                       hgood_reg, hgood_next;
    logic                       hhold_reg, hhold_next;
    logic [15:0]                lheight_reg, lheight_next;

    logic                       present;
    logic [7:0]                 qual;
    logic [15:0]                height;
    logic [10:0]                qsum;
    logic signed [HTIMER_W-1:0] tick_s;
    logic signed [HTIMER_W-1:0] hq_s;

    // Source select: primary first
    assign present = item.primary_present | item.fused_present;
    assign qual    = item.primary_present ? item.primary_quality   : item.fused_quality;
    assign height  = item.primary_present ? item.primary_height_cm : item.fused_height_cm;
    assign qsum    = {1'b0, qtimer_reg} + {3'b000, item.tick_ms};
    assign tick_s  = $signed({{(HTIMER_W-8){1'b0}}, item.tick_ms});
    assign hq_s    = $signed({{(HTIMER_W-11){1'b0}}, regs.height_qualify_ms});

    always_comb
    begin
        qtimer_next  = qtimer_reg;
        qgood_next   = qgood_reg;
        htimer_next  = htimer_reg;
        hgood_next   = hgood_reg;
        hhold_next   = hhold_reg;
        lheight_next = lheight_reg;
        res.flow_enable        = 1'b0;
        res.flow_height_enable = 1'b0;

        if (present)
        begin
            // Quality: must persist, any bad sample clears
            if (qual > regs.quality_threshold)
            begin
                if ({6'd0, qtimer_reg} < regs.quality_qualify_ms)
                    qtimer_next = qsum[10] ? QTIMER_MAX : qsum[9:0];
                else
                    qgood_next = 1'b1;
            end
            else
            begin
                qtimer_next = '0;
                qgood_next  = 1'b0;
            end

            // Height: count up while valid, down while invalid
            if (height < regs.height_limit_cm)
            begin
                lheight_next = height;
                if (htimer_reg < hq_s)
                    htimer_next = htimer_reg + tick_s;
                else
                begin
                    hgood_next = 1'b1;
                    hhold_next = 1'b1;
                end
            end
            else
            begin
                if (htimer_reg > $signed({HTIMER_W{1'b0}}))
                    htimer_next = htimer_reg - tick_s;
                else
                begin
                    hgood_next = 1'b0;
                    hhold_next = 1'b0;
                end
            end

            // Position hold gates both enables
            if (item.position_hold)
                res.flow_enable = hgood_next & qgood_next;
            else
                hhold_next = 1'b0;
            res.flow_height_enable = hhold_next;
        end

        res.uwb_enable      = item.uwb_online & item.position_hold;
        res.camera_enable   = ~item.camera_offline & item.position_hold;
        res.valid_height_cm = lheight_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qtimer_reg  <= '0;
            qgood_reg   <= 1'b0;
            htimer_reg  <= '0;
            hgood_reg   <= 1'b0;
            hhold_reg   <= 1'b0;
            lheight_reg <= '0;
        end
        else if (step)
        begin
            qtimer_reg  <= qtimer_next;
            qgood_reg   <= qgood_next;
            htimer_reg  <= htimer_next;
            hgood_reg   <= hgood_next;
            hhold_reg   <= hhold_next;
            lheight_reg <= lheight_next;
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking bench for the flow sensor validity qualifier top level.
// Needs fsvq_pkg, the fsvq_if channel interfaces and the block's RTL.
// Runs a directed tick table, then random ticks under several register settings.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fsvq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 6;    // margin after the last awaited result
    localparam int HOLD_OFF_LEN = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_TICKS  = 100;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_EVERY3} ready_mode_e;

    // One row of the directed table; res is only used where known is set
    typedef struct {
        fsvq_item_t   it;
        bit           known;
        fsvq_result_t res;
    } tick_row_t;

    logic clk;
    logic rst_n;

    fsvq_item_if   item_ch();
    fsvq_result_if res_ch();
    fsvq_cfg_if    cfg_ch();

    flow_sensor_validity_qualifier_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Shadow of the register file and of the qualification state
    fsvq_cfg_t    shadow;
    int           q_timer;
    bit           q_ok;
    int           h_timer;
    bit           h_ok;
    bit           h_hold;
    logic [15:0]  last_good_height;

    fsvq_result_t pending_q[$];
    tick_row_t    dir_rows[$];

    int n_errors;
    int n_ticks;
    int n_results;
    int n_writes;
    int cycles;

    // Sender pacing
    int burst_left;
    int no_gap_left;

    // Receiver hold-off request, bumped by the stimulus process
    int rx_hold_req;
    int rx_hold_seen;
    int rx_hold_left;
    ready_mode_e rx_mode;
    int rx_mode_left;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout, %0d results still awaited", $realtime, pending_q.size());
            $display("** flow_sensor_validity_qualifier_unit: FAILED **");
            $finish;
        end
    end

    // Predictor: one tick through the qualification rules
    function automatic fsvq_result_t qualify_tick(input fsvq_item_t it);
        fsvq_result_t r;
        logic [7:0]   q;
        logic [15:0]  h;
        int           tick;
        int           qq;
        int           hq;
        r    = '0;
        tick = it.tick_ms;
        qq   = shadow.quality_qualify_ms;
        hq   = shadow.height_qualify_ms;
        if (it.primary_present || it.fused_present)
        begin
            q = it.primary_present ? it.primary_quality   : it.fused_quality;
            h = it.primary_present ? it.primary_height_cm : it.fused_height_cm;

            // quality must persist; any bad sample clears at once
            if (q > shadow.quality_threshold)
            begin
                if (q_timer < qq)
                begin
                    q_timer += tick;
                    if (q_timer > QTIMER_MAX)
                        q_timer = QTIMER_MAX;
                end
                else
                    q_ok = 1'b1;
            end
            else
            begin
                q_timer = 0;
                q_ok    = 1'b0;
            end

            // height counts up below the limit, down at or above it
            if (h < shadow.height_limit_cm)
            begin
                last_good_height = h;
                if (h_timer < hq)
                    h_timer += tick;
                else
                begin
                    h_ok   = 1'b1;
                    h_hold = 1'b1;
                end
            end
            else
            begin
                if (h_timer > 0)
                    h_timer -= tick;
                else
                begin
                    h_ok   = 1'b0;
                    h_hold = 1'b0;
                end
            end

            if (it.position_hold)
                r.flow_enable = h_ok && q_ok;
            else
                h_hold = 1'b0;
            r.flow_height_enable = h_hold;
        end
        r.uwb_enable      = it.uwb_online && it.position_hold;
        r.camera_enable   = !it.camera_offline && it.position_hold;
        r.valid_height_cm = last_good_height;
        return r;
    endfunction

    function automatic fsvq_item_t mk_tick(input int tick, input bit pp, input bit fp,
                                           input int pq, input int ph, input int fq,
                                           input int lh, input bit hold, input bit uwb,
                                           input bit coff);
        fsvq_item_t it;
        it.tick_ms           = 8'(tick);
        it.primary_present   = pp;
        it.fused_present     = fp;
        it.primary_quality   = 8'(pq);
        it.primary_height_cm = 16'(ph);
        it.fused_quality     = 8'(fq);
        it.fused_height_cm   = 16'(lh);
        it.position_hold     = hold;
        it.uwb_online        = uwb;
        it.camera_offline    = coff;
        return it;
    endfunction

    function automatic void add_row(input fsvq_item_t it, input bit known,
                                    input fsvq_result_t res);
        tick_row_t row;
        row.it    = it;
        row.known = known;
        row.res   = res;
        dir_rows.push_back(row);
    endfunction

    // Random tick: mostly a plausible flight with a live source, some noise
    function automatic fsvq_item_t rand_tick();
        fsvq_item_t  it;
        logic [63:0] raw;
        int thr;
        int hl;
        int sel;
        int qv;
        int hv;
        raw = {$urandom, $urandom};
        it  = raw[$bits(fsvq_item_t)-1:0];
        thr = shadow.quality_threshold;
        hl  = shadow.height_limit_cm;
        if ($urandom_range(99, 0) < 15)
            return it;

        sel = $urandom_range(9, 0);
        it.primary_present = (sel < 7);
        it.fused_present   = (sel >= 5);

        if ($urandom_range(9, 0) < 9 && thr < 255)
            qv = $urandom_range(255, thr + 1);
        else
            qv = $urandom_range(255, 0);
        if ($urandom_range(9, 0) < 8 && hl > 0)
            hv = $urandom_range(hl - 1, 0);
        else
            hv = $urandom_range(65535, hl);

        if (it.primary_present)
        begin
            it.primary_quality   = 8'(qv);
            it.primary_height_cm = 16'(hv);
        end
        else
        begin
            it.fused_quality   = 8'(qv);
            it.fused_height_cm = 16'(hv);
        end

        case ($urandom_range(9, 0))
            0, 1:    it.tick_ms = $urandom_range(1, 0) ? 8'd255 : 8'd0;
            2, 3, 4: it.tick_ms = 8'($urandom_range(15, 0));
            default: it.tick_ms = 8'($urandom_range(255, 0));
        endcase
        it.position_hold = ($urandom_range(9, 0) != 0);
        return it;
    endfunction

    // Offer one tick until it is taken, then record what it should produce
    task automatic drive_tick(input fsvq_item_t it, input bit known, input fsvq_result_t res);
        fsvq_result_t pred;
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        pred = qualify_tick(it);
        pending_q.push_back(known ? res : pred);
        n_ticks++;
    endtask

    // Bursts of random length with random gaps between them
    task automatic pace();
        int gap;
        if (no_gap_left > 0)
        begin
            no_gap_left--;
            return;
        end
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(20, 1);
        gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait for every awaited result, then let the pipe settle
    task automatic drain(input int settle);
        item_ch.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= fsvq_cfg_wr_t'{reg_index: idx, wdata: val};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            CFG_QUALITY_THRESHOLD:  shadow.quality_threshold  = val[7:0];
            CFG_QUALITY_QUALIFY_MS: shadow.quality_qualify_ms = val;
            CFG_HEIGHT_LIMIT_CM:    shadow.height_limit_cm    = val;
            CFG_HEIGHT_QUALIFY_MS:  shadow.height_qualify_ms  = val[10:0];
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic set_config(input int thr, input int qq, input int hl, input int hq);
        write_reg(CFG_QUALITY_THRESHOLD, 16'(thr));
        write_reg(CFG_QUALITY_QUALIFY_MS, 16'(qq));
        write_reg(CFG_HEIGHT_LIMIT_CM, 16'(hl));
        write_reg(CFG_HEIGHT_QUALIFY_MS, 16'(hq));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic cmp_field(input string name, input int e, input int a);
        if (e != a)
        begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $realtime, name, e, a);
            n_errors++;
        end
    endtask

    task automatic take_result(input fsvq_result_t got);
        fsvq_result_t e;
        n_results++;
        if (pending_q.size() == 0)
        begin
            $display("%0t ns: unexpected result, expected none actual %h", $realtime, got);
            n_errors++;
            return;
        end
        e = pending_q.pop_front();
        cmp_field("flow_enable",        e.flow_enable,        got.flow_enable);
        cmp_field("flow_height_enable", e.flow_height_enable, got.flow_height_enable);
        cmp_field("uwb_enable",         e.uwb_enable,         got.uwb_enable);
        cmp_field("camera_enable",      e.camera_enable,      got.camera_enable);
        cmp_field("valid_height_cm",    e.valid_height_cm,    got.valid_height_cm);
    endtask

    // Receiver: checks each transfer, then picks ready from its own pattern
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            take_result(res_ch.data);
        if (rx_hold_seen != rx_hold_req)
        begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = HOLD_OFF_LEN;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = ready_mode_e'($urandom_range(3, 0));
                rx_mode_left = $urandom_range(60, 10);
            end
            else
                rx_mode_left--;
            case (rx_mode)
                RDY_ALWAYS: res_ch.ready <= 1'b1;
                RDY_COIN:   res_ch.ready <= ($urandom_range(1, 0) != 0);
                RDY_MOSTLY: res_ch.ready <= ($urandom_range(3, 0) != 0);
                RDY_EVERY3: res_ch.ready <= (cycles % 3 == 0);
                default:    res_ch.ready <= 1'b1;
            endcase
        end
    end

    // Stimulus
    initial
    begin
        int thr;
        int qq;
        int hl;
        int hq;
        rst_n         = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        res_ch.ready  = 1'b0;
        n_errors      = 0;
        n_ticks       = 0;
        n_results     = 0;
        n_writes      = 0;
        cycles        = 0;
        burst_left    = 0;
        no_gap_left   = 0;
        rx_hold_req   = 0;
        rx_hold_seen  = 0;
        rx_hold_left  = 0;
        rx_mode       = RDY_ALWAYS;
        rx_mode_left  = 0;

        shadow.quality_threshold  = QUALITY_THRESHOLD_RST;
        shadow.quality_qualify_ms = QUALITY_QUALIFY_MS_RST;
        shadow.height_limit_cm    = HEIGHT_LIMIT_CM_RST;
        shadow.height_qualify_ms  = HEIGHT_QUALIFY_MS_RST;
        q_timer          = 0;
        q_ok             = 1'b0;
        h_timer          = 0;
        h_ok             = 1'b0;
        h_hold           = 1'b0;
        last_good_height = '0;

        // Directed table, reset register values
        // no source straight after reset: only the link enables move
        add_row(mk_tick(255, 0, 0, 255, 0, 255, 0, 1, 1, 0), 1,
                fsvq_result_t'{1'b0, 1'b0, 1'b1, 1'b1, 16'd0});
        add_row(mk_tick(0, 0, 0, 0, 65535, 0, 65535, 0, 1, 1), 1,
                fsvq_result_t'{1'b0, 1'b0, 1'b0, 1'b0, 16'd0});
        // source present out of position hold: timers run, height latched
        add_row(mk_tick(255, 1, 0, 255, 100, 0, 0, 0, 0, 0), 1,
                fsvq_result_t'{1'b0, 1'b0, 1'b0, 1'b0, 16'd100});
        // good primary until quality then height qualify
        repeat (4)
            add_row(mk_tick(255, 1, 0, 255, 100, 0, 65535, 1, 1, 0), 0, '0);
        // height above limit: count down, then clear
        repeat (5)
            add_row(mk_tick(255, 1, 0, 255, 65535, 0, 0, 1, 0, 1), 0, '0);
        // quality equal to threshold is bad
        add_row(mk_tick(10, 1, 0, 50, 100, 255, 0, 1, 1, 0), 0, '0);
        // fused source alone, primary fields ignored
        add_row(mk_tick(0, 0, 1, 0, 65535, 255, 0, 1, 1, 0), 0, '0);
        // both present: primary wins
        add_row(mk_tick(128, 1, 1, 0, 599, 255, 65535, 1, 0, 0), 0, '0);
        // fused exactly at the height limit, quality just above threshold
        add_row(mk_tick(1, 0, 1, 51, 0, 51, 600, 1, 1, 1), 0, '0);
        add_row(mk_tick(255, 0, 1, 255, 0, 255, 599, 0, 1, 0), 0, '0);
        // no source again: state frozen
        add_row(mk_tick(0, 0, 0, 255, 0, 255, 0, 1, 1, 0), 0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            drive_tick(dir_rows[i].it, dir_rows[i].known, dir_rows[i].res);
            pace();
        end
        drain(SETTLE);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_config(0, 0, 65535, 0);
                1: set_config(255, 65535, 0, 1792);
                2: set_config(50, 1023, 1000, 1792);
                3: set_config(128, 1024, 300, 1);
                default:
                begin
                    thr = $urandom_range(255, 0);
                    qq  = ($urandom_range(9, 0) < 7) ? $urandom_range(1100, 0)
                                                     : $urandom_range(65535, 0);
                    hl  = ($urandom_range(1, 0) != 0) ? $urandom_range(2000, 0)
                                                      : $urandom_range(65535, 0);
                    hq  = $urandom_range(1792, 0);
                    set_config(thr, qq, hl, hq);
                end
            endcase
            for (int k = 0; k < PHASE_TICKS; k++)
            begin
                // long receiver hold-off with the sender pushing back to back
                if (ph == 2 && k == 30)
                begin
                    rx_hold_req++;
                    no_gap_left = 60;
                end
                // sender waits for the pipe to empty mid-phase
                if (ph == 4 && k == 50)
                    drain(0);
                drive_tick(rand_tick(), 0, '0);
                pace();
            end
            drain(SETTLE);
        end

        $display("Ran %0d ticks (%0d results checked) over %0d register writes.",
                 n_ticks, n_results, n_writes);
        $display("Covered reset values, extreme settings, hold-off back-pressure and drain.");
        if (n_errors == 0)
            $display("** flow_sensor_validity_qualifier_unit: PASSED **");
        else
            $display("** flow_sensor_validity_qualifier_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
sv/fsvq_pkg.sv
sv/fsvq_if.sv
sv/fsvq_cfg_regs.sv
sv/fsvq_core.sv
sv/flow_sensor_validity_qualifier_unit.sv
tb/tb_top.sv
